// ----- hdl/ial_pkg.sv -----
// Shared types and constants for the indexed array list unit.
`timescale 1ns / 1ps
`default_nettype none

package ial_pkg;

    // List geometry
    localparam int LIST_DEPTH = 64;
    localparam int ENTRY_BITS = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_BITS  = IDX_W + ENTRY_BITS;
    localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ENTRY_BITS + CNT_W + STAT_W;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_APPEND = 3'd1,
        OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ----- hdl/indexed_array_list_unit.sv -----
// Bounded ordered list in a single-port-write array with a fill count.
//
//  channel   dir  handshake                      tdata / tuser
//  s_axis    in   s_axis_tvalid / s_axis_tready  request: op, position, entry value
//  m_axis    out  m_axis_tvalid / m_axis_tready  result: value, count, status, valid
//
//  A read waits on the registered slot read; insert shifts the entries from
//  the position up before it writes, and remove shifts the later entries down.
//  The slot memory moves one entry per cycle through its one read and one
//  write port, which sets the shift time. A request is taken while the
//  sequencer is idle and the result register is empty or being drained.
//  Reset clears the count and the control state; slot contents stay as they are.
`timescale 1ns / 1ps
`default_nettype none

module indexed_array_list_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [5:0] position, [21:6] entry_value, rest zero
    input  wire logic [ial_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [2:0] operation
    input  wire logic [ial_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [15:0] read_value, [22:16] entry_count, [24:23] status, rest zero
    output logic [ial_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // [0] read_valid
    output logic                                    m_axis_tuser
);

    localparam int IDX_W = ial_pkg::IDX_W;
    localparam int CNT_W = ial_pkg::CNT_W;
    localparam int EB    = ial_pkg::ENTRY_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SHIFT_UP,
        S_INS_WR,
        S_SHIFT_DN
    } t_state;

    // Slot memory
    logic [EB-1:0]    r_mem [ial_pkg::LIST_DEPTH];
    logic [EB-1:0]    r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [EB-1:0]    mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    // Sequencer and result registers
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_src, n_src;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic [EB-1:0]      r_val, n_val;
    logic               r_out_valid, n_out_valid;
    logic [EB-1:0]      r_out_value, n_out_value;
    logic               r_out_rvalid, n_out_rvalid;
    logic [CNT_W-1:0]   r_out_count, n_out_count;
    ial_pkg::t_status   r_out_status, n_out_status;

    // Request fields
    ial_pkg::t_op       in_op;
    logic [IDX_W-1:0]   in_pos;
    logic [EB-1:0]      in_val;
    logic               accept;
    logic               out_free;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   pos_ext;
    logic               is_full;

    assign in_op   = ial_pkg::t_op'(s_axis_tuser);
    assign in_pos  = s_axis_tdata[IDX_W-1:0];
    assign in_val  = s_axis_tdata[IDX_W +: EB];
    assign cnt_m1  = r_count - CNT_W'(1);
    assign pos_ext = CNT_W'(in_pos);
    assign is_full = (r_count == CNT_W'(ial_pkg::LIST_DEPTH));

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Sequencer next state and memory control
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_src        = r_src;
        n_pos        = r_pos;
        n_val        = r_val;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_value  = r_out_value;
        n_out_rvalid = r_out_rvalid;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_waddr    = r_src;
        mem_wdata    = r_rdata;
        mem_raddr    = r_src;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos        = in_pos;
                    n_val        = in_val;
                    n_out_value  = '0;
                    n_out_rvalid = 1'b0;
                    n_out_status = ial_pkg::ST_OK;
                    case (in_op)
                        ial_pkg::OP_READ: begin
                            if (pos_ext < r_count) begin
                                mem_raddr = in_pos;
                                n_state   = S_RD_WAIT;
                            end else begin
                                n_out_status = ial_pkg::ST_RANGE;
                                n_out_count  = r_count;
                                n_out_valid  = 1'b1;
                            end
                        end
                        ial_pkg::OP_APPEND: begin
                            if (is_full) begin
                                n_out_status = ial_pkg::ST_FULL;
                                n_out_count  = r_count;
                            end else begin
                                mem_we      = 1'b1;
                                mem_waddr   = r_count[IDX_W-1:0];
                                mem_wdata   = in_val;
                                n_count     = r_count + CNT_W'(1);
                                n_out_count = r_count + CNT_W'(1);
                            end
                            n_out_valid = 1'b1;
                        end
                        ial_pkg::OP_INSERT: begin
                            if (is_full) begin
                                n_out_status = ial_pkg::ST_FULL;
                                n_out_count  = r_count;
                                n_out_valid  = 1'b1;
                            end else if (pos_ext >= r_count) begin
                                n_out_status = ial_pkg::ST_RANGE;
                                n_out_count  = r_count;
                                n_out_valid  = 1'b1;
                            end else begin
                                // start with the last entry
                                mem_raddr = cnt_m1[IDX_W-1:0];
                                n_src     = cnt_m1[IDX_W-1:0];
                                n_state   = S_SHIFT_UP;
                            end
                        end
                        ial_pkg::OP_REMOVE: begin
                            if (pos_ext >= r_count) begin
                                n_out_status = ial_pkg::ST_RANGE;
                                n_out_count  = r_count;
                                n_out_valid  = 1'b1;
                            end else if (pos_ext == cnt_m1) begin
                                // last entry: nothing to move
                                n_count     = cnt_m1;
                                n_out_count = cnt_m1;
                                n_out_valid = 1'b1;
                            end else begin
                                mem_raddr = in_pos + IDX_W'(1);
                                n_src     = in_pos + IDX_W'(1);
                                n_state   = S_SHIFT_DN;
                            end
                        end
                        ial_pkg::OP_CLEAR: begin
                            n_count     = '0;
                            n_out_count = '0;
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out_count = r_count;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_RD_WAIT: begin
                n_out_value  = r_rdata;
                n_out_rvalid = 1'b1;
                n_out_count  = r_count;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end

            // Move entries up one slot, last entry first
            S_SHIFT_UP: begin
                mem_we    = 1'b1;
                mem_waddr = r_src + IDX_W'(1);
                mem_wdata = r_rdata;
                if (r_src == r_pos) begin
                    n_state = S_INS_WR;
                end else begin
                    mem_raddr = r_src - IDX_W'(1);
                    n_src     = r_src - IDX_W'(1);
                end
            end

            S_INS_WR: begin
                mem_we      = 1'b1;
                mem_waddr   = r_pos;
                mem_wdata   = r_val;
                n_count     = r_count + CNT_W'(1);
                n_out_count = r_count + CNT_W'(1);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end

            // Move entries down one slot, lowest first
            S_SHIFT_DN: begin
                mem_we    = 1'b1;
                mem_waddr = r_src - IDX_W'(1);
                mem_wdata = r_rdata;
                if (CNT_W'(r_src) == cnt_m1) begin
                    n_count     = cnt_m1;
                    n_out_count = cnt_m1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    mem_raddr = r_src + IDX_W'(1);
                    n_src     = r_src + IDX_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Hold state, count and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_src        <= n_src;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_out_value  <= n_out_value;
        r_out_rvalid <= n_out_rvalid;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    // Drive the result channel
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_rvalid;
    assign m_axis_tdata  = {{(ial_pkg::OUT_TDATA_W - ial_pkg::OUT_DATA_BITS){1'b0}},
                            r_out_status, r_out_count, r_out_value};

endmodule

`default_nettype wire
